FILE: design/tkz_pkg.sv
// Shared types, constants and keyword tables of the script source tokenizer.
package tkz_pkg;

   localparam int KEYWORD_MAX_LEN = 7;
   localparam int POSITION_BITS   = 24;
   localparam int QUEUE_DEPTH     = 4;

   // Token kinds.
   localparam logic [5:0] KIND_IDENT   = 6'd0;
   localparam logic [5:0] KIND_INT     = 6'd22;
   localparam logic [5:0] KIND_FLOAT   = 6'd23;
   localparam logic [5:0] KIND_STRING  = 6'd24;
   localparam logic [5:0] KIND_PATH    = 6'd25;
   localparam logic [5:0] KIND_DOT     = 6'd26;
   localparam logic [5:0] KIND_OP      = 6'd27;
   localparam logic [5:0] KIND_QUEST   = 6'd28;
   localparam logic [5:0] KIND_COLON   = 6'd29;
   localparam logic [5:0] KIND_SEMI    = 6'd30;
   localparam logic [5:0] KIND_LPAREN  = 6'd31;
   localparam logic [5:0] KIND_RPAREN  = 6'd32;
   localparam logic [5:0] KIND_COMMA   = 6'd33;
   localparam logic [5:0] KIND_LBRACK  = 6'd34;
   localparam logic [5:0] KIND_RBRACK  = 6'd35;
   localparam logic [5:0] KIND_LBRACE  = 6'd36;
   localparam logic [5:0] KIND_RBRACE  = 6'd37;
   localparam logic [5:0] KIND_ASSIGN  = 6'd38;
   localparam logic [5:0] KIND_FATARROW = 6'd39;
   localparam logic [5:0] KIND_ARROW   = 6'd40;
   localparam logic [5:0] KIND_EOF     = 6'd41;
   localparam logic [5:0] KIND_STRCHAR = 6'd42;
   localparam logic [5:0] KIND_ERROR   = 6'd43;

   // Operator codes.
   localparam logic [3:0] OP_NONE = 4'd0;
   localparam logic [3:0] OP_ADD  = 4'd1;
   localparam logic [3:0] OP_SUB  = 4'd2;
   localparam logic [3:0] OP_MUL  = 4'd3;
   localparam logic [3:0] OP_DIV  = 4'd4;
   localparam logic [3:0] OP_MOD  = 4'd5;
   localparam logic [3:0] OP_LT   = 4'd6;
   localparam logic [3:0] OP_LE   = 4'd7;
   localparam logic [3:0] OP_GT   = 4'd8;
   localparam logic [3:0] OP_GE   = 4'd9;
   localparam logic [3:0] OP_NE   = 4'd10;
   localparam logic [3:0] OP_EQ   = 4'd11;
   localparam logic [3:0] OP_AND  = 4'd12;
   localparam logic [3:0] OP_OR   = 4'd13;

   // Error codes.
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_UNTERM  = 2'd1;
   localparam logic [1:0] ERR_UNKNOWN = 2'd2;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_LINECOM, MODE_SLASH, MODE_BLOCK, MODE_BLOCKSTAR, MODE_DOT,
      MODE_PATH, MODE_IDENT, MODE_INT, MODE_FRAC, MODE_STR, MODE_ESC, MODE_SYM,
      MODE_ERROR
   } mode_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [3:0]  opc;
      logic [23:0] start;
      logic [23:0] len;
      logic [23:0] line;
      logic [7:0]  chr;
      logic [1:0]  err;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0] cnt;
      result_type e0;
      result_type e1;
   } push_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] kind;
      logic [3:0] opc;
   } sym_type;

   typedef logic [7:0] kwbuf_type [7];

   // Keywords are right-justified: the last character sits in the low byte.
   localparam logic [55:0] KW_WORD [21] = '{
      "func", "let", "if", "else", "for", "while", "end", "return", "switch",
      "case", "default", "try", "catch", "print", "int", "string", "in", "use",
      "as", "True", "False"};
   localparam logic [3:0] KW_SIZE [21] = '{
      4'd4, 4'd3, 4'd2, 4'd4, 4'd3, 4'd5, 4'd3, 4'd6, 4'd6, 4'd4, 4'd7, 4'd3,
      4'd5, 4'd5, 4'd3, 4'd6, 4'd2, 4'd3, 4'd2, 4'd4, 4'd5};

   function automatic logic [5:0] kw_kind(input kwbuf_type kb, input logic [3:0] len);
      logic [5:0] kind;
      logic       eq;
      kind = KIND_IDENT;
      for (int k = 20; k >= 0; k--) begin
         eq = (len == KW_SIZE[k]);
         for (int i = 0; i < 7; i++) begin
            if (i < int'(KW_SIZE[k]) &&
                kb[i] != KW_WORD[k][8*(int'(KW_SIZE[k]) - 1 - i) +: 8]) begin
               eq = 1'b0;
            end
         end
         if (eq) begin
            kind = 6'(k + 1);
         end
      end
      return kind;
   endfunction

   function automatic sym_type single_sym(input logic [7:0] b);
      sym_type s;
      s = '{hit: 1'b1, kind: KIND_OP, opc: OP_NONE};
      case (b)
         "+": s.opc = OP_ADD;
         "*": s.opc = OP_MUL;
         "%": s.opc = OP_MOD;
         "?": s.kind = KIND_QUEST;
         ":": s.kind = KIND_COLON;
         ";": s.kind = KIND_SEMI;
         "(": s.kind = KIND_LPAREN;
         ")": s.kind = KIND_RPAREN;
         ",": s.kind = KIND_COMMA;
         "[": s.kind = KIND_LBRACK;
         "]": s.kind = KIND_RBRACK;
         "{": s.kind = KIND_LBRACE;
         "}": s.kind = KIND_RBRACE;
         default: s.hit = 1'b0;
      endcase
      return s;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == " ") || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

endpackage

FILE: design/tkz_if.sv
// Valid/ready channel interfaces for source bytes and tokenizer results.
interface tkz_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;
   logic       end_of_source;
   modport source (output valid, source_byte, end_of_source, input ready);
   modport sink (input valid, source_byte, end_of_source, output ready);
endinterface

interface tkz_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_kind;
   logic [3:0]  operator_code;
   logic [23:0] start_offset;
   logic [23:0] token_length;
   logic [23:0] line_number;
   logic [7:0]  decoded_char;
   logic [1:0]  error_code;
   logic        last_of_run;
   modport source (output valid, token_kind, operator_code, start_offset, token_length,
                   line_number, decoded_char, error_code, last_of_run, input ready);
   modport sink (input valid, token_kind, operator_code, start_offset, token_length,
                 line_number, decoded_char, error_code, last_of_run, output ready);
endinterface

FILE: design/tkz_front.sv
// Front end: lexer state machine that takes source bytes and pushes up to two results.
module tkz_front #(
   parameter int KEYWORD_MAX_LEN = tkz_pkg::KEYWORD_MAX_LEN,
   parameter int POSITION_BITS   = tkz_pkg::POSITION_BITS
) (
   input  logic              clock,
   input  logic              reset,
   tkz_req_if.sink           req_ch,
   input  logic              room,
   output tkz_pkg::push_type push
);
   localparam int P = POSITION_BITS;

   tkz_pkg::mode_type mode_ff, mode_in;
   logic [7:0]   pend_ff, pend_in;
   logic [P-1:0] start_ff, start_in, span_ff, span_in, offs_ff, offs_in, line_ff, line_in;
   logic [7:0]   kw_ff [KEYWORD_MAX_LEN];
   logic [7:0]   kw_in [KEYWORD_MAX_LEN];
   logic [3:0]   idlen_ff, idlen_in;

   logic accept, fin, run_p, cons, ident_ch, sep;
   logic [7:0] b, pb;
   logic [P-1:0] span_inc;
   tkz_pkg::kwbuf_type kb;
   tkz_pkg::sym_type   sym;
   tkz_pkg::result_type ra, rb;
   logic a_v, b_v;

   function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
      return (&v) ? v : v + P'(1);
   endfunction

   function automatic logic [23:0] clamp(input logic [P-1:0] v);
      return (v > P'(24'hFFFFFF)) ? 24'hFFFFFF : 24'(v);
   endfunction

   function automatic tkz_pkg::result_type mk(input logic [5:0] kind, input logic [3:0] opc,
                                              input logic [P-1:0] at, input logic [P-1:0] len,
                                              input logic [P-1:0] line, input logic [7:0] chr,
                                              input logic [1:0] err);
      tkz_pkg::result_type r;
      r = '{kind: kind, opc: opc, start: clamp(at), len: clamp(len), line: clamp(line),
            chr: chr, err: err, last: 1'b0};
      return r;
   endfunction

   assign accept   = req_ch.valid && room;
   assign req_ch.ready = room;
   assign b        = req_ch.source_byte;
   assign fin      = req_ch.end_of_source || (b == 8'd0);
   assign pb       = fin ? 8'd0 : b;
   assign span_inc = sat_inc(span_ff);
   assign ident_ch = tkz_pkg::is_alpha(pb) || tkz_pkg::is_digit(pb) || pb == "_";
   assign sep      = pb == " " || pb == 8'd9 || pb == 8'd10 || pb == 8'd13 || pb == 8'd0;
   assign sym      = tkz_pkg::single_sym(b);

   always_comb begin
      for (int i = 0; i < 7; i++) begin
         kb[i] = kw_ff[i];
      end
   end

   // At the end marker a path, an open string, comments and the error state do not
   // take the usual lookahead step.
   assign run_p = !fin || !(mode_ff == tkz_pkg::MODE_PATH || mode_ff == tkz_pkg::MODE_STR ||
                            mode_ff == tkz_pkg::MODE_ESC || mode_ff == tkz_pkg::MODE_LINECOM ||
                            mode_ff == tkz_pkg::MODE_BLOCK ||
                            mode_ff == tkz_pkg::MODE_BLOCKSTAR ||
                            mode_ff == tkz_pkg::MODE_ERROR);

   // Next state.
   always_comb begin
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      start_in = start_ff;
      span_in  = span_ff;
      offs_in  = offs_ff;
      line_in  = line_ff;
      idlen_in = idlen_ff;
      kw_in    = kw_ff;
      cons     = 1'b1;
      if (run_p) begin
         case (mode_ff)
            tkz_pkg::MODE_LINECOM: begin
               if (pb == 8'd10) begin
                  mode_in = tkz_pkg::MODE_IDLE;
                  cons    = 1'b0;
               end
            end
            tkz_pkg::MODE_SLASH: begin
               if (pb == "*") mode_in = tkz_pkg::MODE_BLOCK;
               else begin
                  mode_in = tkz_pkg::MODE_IDLE;
                  cons    = 1'b0;
               end
            end
            tkz_pkg::MODE_BLOCK: begin
               if (pb == "*") mode_in = tkz_pkg::MODE_BLOCKSTAR;
               else if (pb == 8'd10) line_in = sat_inc(line_ff);
            end
            tkz_pkg::MODE_BLOCKSTAR: begin
               if (pb == "/") mode_in = tkz_pkg::MODE_IDLE;
               else if (pb != "*") begin
                  if (pb == 8'd10) line_in = sat_inc(line_ff);
                  mode_in = tkz_pkg::MODE_BLOCK;
               end
            end
            tkz_pkg::MODE_DOT: begin
               if (pb == "/") begin
                  span_in = span_inc;
                  mode_in = tkz_pkg::MODE_PATH;
               end else if (tkz_pkg::is_digit(pb)) begin
                  span_in = span_inc;
                  mode_in = tkz_pkg::MODE_FRAC;
               end else if (pb == ".") mode_in = tkz_pkg::MODE_ERROR;
               else begin
                  mode_in = tkz_pkg::MODE_IDLE;
                  cons    = 1'b0;
               end
            end
            tkz_pkg::MODE_PATH: begin
               if (tkz_pkg::is_space(pb)) begin
                  mode_in = tkz_pkg::MODE_IDLE;
                  cons    = 1'b0;
               end else span_in = span_inc;
            end
            tkz_pkg::MODE_IDENT: begin
               if (ident_ch) begin
                  for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
                     if (int'(idlen_ff) == i) kw_in[i] = pb;
                  end
                  if (idlen_ff != 4'd15) idlen_in = idlen_ff + 4'd1;
                  span_in = span_inc;
               end else begin
                  mode_in = tkz_pkg::MODE_IDLE;
                  cons    = 1'b0;
               end
            end
            tkz_pkg::MODE_INT: begin
               if (tkz_pkg::is_digit(pb)) span_in = span_inc;
               else if (pb == ".") begin
                  span_in = span_inc;
                  mode_in = tkz_pkg::MODE_FRAC;
               end else begin
                  mode_in = tkz_pkg::MODE_IDLE;
                  cons    = 1'b0;
               end
            end
            tkz_pkg::MODE_FRAC: begin
               if (tkz_pkg::is_digit(pb)) span_in = span_inc;
               else begin
                  mode_in = tkz_pkg::MODE_IDLE;
                  cons    = 1'b0;
               end
            end
            tkz_pkg::MODE_STR: begin
               span_in = span_inc;
               if (pb == "\"") mode_in = tkz_pkg::MODE_IDLE;
               else if (pb == "\\") mode_in = tkz_pkg::MODE_ESC;
            end
            tkz_pkg::MODE_ESC: begin
               span_in = span_inc;
               mode_in = tkz_pkg::MODE_STR;
            end
            tkz_pkg::MODE_SYM: begin
               mode_in = tkz_pkg::MODE_IDLE;
               if ((pend_ff == "=" && (pb == "=" || pb == ">")) ||
                   ((pend_ff == "<" || pend_ff == ">" || pend_ff == "!") && pb == "=") ||
                   (pend_ff == "-" && pb == ">")) begin
                  span_in = span_inc;
               end else if (pend_ff == "!") mode_in = tkz_pkg::MODE_ERROR;
               else cons = 1'b0;
            end
            tkz_pkg::MODE_ERROR: cons = 1'b1;
            default: begin
               mode_in = tkz_pkg::MODE_IDLE;
               cons    = 1'b0;
            end
         endcase
      end
      if (fin) begin
         mode_in  = tkz_pkg::MODE_IDLE;
         pend_in  = 8'd0;
         start_in = '0;
         span_in  = '0;
         offs_in  = '0;
         line_in  = P'(1);
         idlen_in = 4'd0;
      end else begin
         if (!cons) begin
            if (tkz_pkg::is_space(b)) begin
               if (b == 8'd10) line_in = sat_inc(line_ff);
            end else begin
               start_in = offs_ff;
               span_in  = P'(1);
               if (b == "#") mode_in = tkz_pkg::MODE_LINECOM;
               else if (b == "/") mode_in = tkz_pkg::MODE_SLASH;
               else if (b == ".") mode_in = tkz_pkg::MODE_DOT;
               else if (b == "\"") mode_in = tkz_pkg::MODE_STR;
               else if (b == "<" || b == ">" || b == "!" || b == "=" || b == "-") begin
                  pend_in = b;
                  mode_in = tkz_pkg::MODE_SYM;
               end else if (tkz_pkg::is_alpha(b) || b == "_") begin
                  kw_in[0] = b;
                  idlen_in = 4'd1;
                  mode_in  = tkz_pkg::MODE_IDENT;
               end else if (tkz_pkg::is_digit(b)) mode_in = tkz_pkg::MODE_INT;
               else if (!sym.hit) mode_in = tkz_pkg::MODE_ERROR;
            end
         end
         offs_in = sat_inc(offs_ff);
      end
   end

   // Results: slot A comes from the pending token, slot B from the fresh byte or the end.
   always_comb begin
      a_v = 1'b0;
      ra  = mk(tkz_pkg::KIND_IDENT, tkz_pkg::OP_NONE, start_ff, span_ff, line_ff, 8'd0,
               tkz_pkg::ERR_NONE);
      if (fin && mode_ff == tkz_pkg::MODE_PATH) begin
         a_v = 1'b1;
         ra.kind = tkz_pkg::KIND_PATH;
      end else if (fin && (mode_ff == tkz_pkg::MODE_STR || mode_ff == tkz_pkg::MODE_ESC)) begin
         a_v = 1'b1;
         ra.kind = tkz_pkg::KIND_ERROR;
         ra.err  = tkz_pkg::ERR_UNTERM;
      end else if (run_p) begin
         case (mode_ff)
            tkz_pkg::MODE_SLASH: begin
               a_v    = pb != "*";
               ra.kind = tkz_pkg::KIND_OP;
               ra.opc  = tkz_pkg::OP_DIV;
            end
            tkz_pkg::MODE_DOT: begin
               if (pb == ".") begin
                  a_v = 1'b1;
                  ra  = mk(tkz_pkg::KIND_ERROR, tkz_pkg::OP_NONE, start_ff, P'(1), line_ff,
                           8'd0, tkz_pkg::ERR_UNKNOWN);
               end else if (pb != "/" && !tkz_pkg::is_digit(pb)) begin
                  a_v = 1'b1;
                  ra.kind = tkz_pkg::KIND_DOT;
               end
            end
            tkz_pkg::MODE_PATH: begin
               a_v = tkz_pkg::is_space(pb);
               ra.kind = tkz_pkg::KIND_PATH;
            end
            tkz_pkg::MODE_IDENT: begin
               a_v = !ident_ch;
               if (sep && idlen_ff == 4'd3 && kb[0] == "a" && kb[1] == "n" && kb[2] == "d") begin
                  ra.kind = tkz_pkg::KIND_OP;
                  ra.opc  = tkz_pkg::OP_AND;
               end else if (sep && idlen_ff == 4'd2 && kb[0] == "o" && kb[1] == "r") begin
                  ra.kind = tkz_pkg::KIND_OP;
                  ra.opc  = tkz_pkg::OP_OR;
               end else ra.kind = tkz_pkg::kw_kind(kb, idlen_ff);
            end
            tkz_pkg::MODE_INT: begin
               a_v = !tkz_pkg::is_digit(pb) && pb != ".";
               ra.kind = tkz_pkg::KIND_INT;
            end
            tkz_pkg::MODE_FRAC: begin
               a_v = !tkz_pkg::is_digit(pb);
               ra.kind = tkz_pkg::KIND_FLOAT;
            end
            tkz_pkg::MODE_STR: begin
               if (pb == "\"") begin
                  a_v = 1'b1;
                  ra  = mk(tkz_pkg::KIND_STRING, tkz_pkg::OP_NONE, start_ff, span_inc, line_ff,
                           8'd0, tkz_pkg::ERR_NONE);
               end else if (pb != "\\") begin
                  a_v = 1'b1;
                  ra  = mk(tkz_pkg::KIND_STRCHAR, tkz_pkg::OP_NONE, offs_ff, P'(1), line_ff,
                           pb, tkz_pkg::ERR_NONE);
               end
            end
            tkz_pkg::MODE_ESC: begin
               a_v = 1'b1;
               ra  = mk(tkz_pkg::KIND_STRCHAR, tkz_pkg::OP_NONE,
                        (offs_ff != '0) ? offs_ff - P'(1) : '0, P'(2), line_ff,
                        (pb == "n") ? 8'd10 : ((pb == "t") ? 8'd9 : pb), tkz_pkg::ERR_NONE);
            end
            tkz_pkg::MODE_SYM: begin
               a_v = 1'b1;
               ra.len = clamp(span_inc);
               case (pend_ff)
                  "=": begin
                     if (pb == "=") begin
                        ra.kind = tkz_pkg::KIND_OP;
                        ra.opc  = tkz_pkg::OP_EQ;
                     end else if (pb == ">") ra.kind = tkz_pkg::KIND_FATARROW;
                     else begin
                        ra.kind = tkz_pkg::KIND_ASSIGN;
                        ra.len  = clamp(span_ff);
                     end
                  end
                  "<", ">": begin
                     ra.kind = tkz_pkg::KIND_OP;
                     if (pb == "=") ra.opc = (pend_ff == "<") ? tkz_pkg::OP_LE : tkz_pkg::OP_GE;
                     else begin
                        ra.opc = (pend_ff == "<") ? tkz_pkg::OP_LT : tkz_pkg::OP_GT;
                        ra.len = clamp(span_ff);
                     end
                  end
                  "!": begin
                     if (pb == "=") begin
                        ra.kind = tkz_pkg::KIND_OP;
                        ra.opc  = tkz_pkg::OP_NE;
                     end else begin
                        ra = mk(tkz_pkg::KIND_ERROR, tkz_pkg::OP_NONE, start_ff, P'(1),
                                line_ff, 8'd0, tkz_pkg::ERR_UNKNOWN);
                     end
                  end
                  "-": begin
                     if (pb == ">") ra.kind = tkz_pkg::KIND_ARROW;
                     else begin
                        ra.kind = tkz_pkg::KIND_OP;
                        ra.opc  = tkz_pkg::OP_SUB;
                        ra.len  = clamp(span_ff);
                     end
                  end
                  default: a_v = 1'b0;
               endcase
            end
            default: a_v = 1'b0;
         endcase
      end

      b_v = 1'b0;
      rb  = mk(tkz_pkg::KIND_EOF, tkz_pkg::OP_NONE, offs_ff, '0, line_ff, 8'd0,
               tkz_pkg::ERR_NONE);
      if (fin) b_v = 1'b1;
      else if (!cons && !tkz_pkg::is_space(b)) begin
         if (sym.hit) begin
            b_v = 1'b1;
            rb  = mk(sym.kind, sym.opc, offs_ff, P'(1), line_ff, 8'd0, tkz_pkg::ERR_NONE);
         end else if (!(b == "#" || b == "/" || b == "." || b == "\"" || b == "<" ||
                        b == ">" || b == "!" || b == "=" || b == "-" || b == "_" ||
                        tkz_pkg::is_alpha(b) || tkz_pkg::is_digit(b))) begin
            b_v = 1'b1;
            rb  = mk(tkz_pkg::KIND_ERROR, tkz_pkg::OP_NONE, offs_ff, P'(1), line_ff, 8'd0,
                     tkz_pkg::ERR_UNKNOWN);
         end
      end
   end

   // Pack the results in order and flag the last one of the item.
   always_comb begin
      push.cnt = accept ? {1'b0, a_v} + {1'b0, b_v} : 2'd0;
      push.e0  = a_v ? ra : rb;
      push.e1  = rb;
      push.e0.last = !(a_v && b_v);
      push.e1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= tkz_pkg::MODE_IDLE;
         pend_ff  <= 8'd0;
         start_ff <= '0;
         span_ff  <= '0;
         offs_ff  <= '0;
         line_ff  <= P'(1);
         idlen_ff <= 4'd0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         pend_ff  <= pend_in;
         start_ff <= start_in;
         span_ff  <= span_in;
         offs_ff  <= offs_in;
         line_ff  <= line_in;
         idlen_ff <= idlen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kw_ff <= kw_in;
      end
   end

endmodule

FILE: design/tkz_queue.sv
// Small result queue between the lexer front end and the output stage.
module tkz_queue (
   input  logic                clock,
   input  logic                reset,
   input  tkz_pkg::push_type   push,
   output logic                room,
   output logic                head_valid,
   output tkz_pkg::result_type head,
   input  logic                pop
);
   localparam int AW = $clog2(tkz_pkg::QUEUE_DEPTH);

   tkz_pkg::result_type q_ff [tkz_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;

   // Room for the two results a single item can cause.
   assign room       = cnt_ff <= (AW+1)'(tkz_pkg::QUEUE_DEPTH - 2);
   assign head_valid = cnt_ff != '0;
   assign head       = q_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff + AW'(push.cnt);
      rp_in  = rp_ff + AW'(pop);
      cnt_in = cnt_ff + (AW+1)'(push.cnt) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) q_ff[wp_ff] <= push.e0;
      if (push.cnt == 2'd2) q_ff[wp_ff + AW'(1)] <= push.e1;
   end

endmodule

FILE: design/tkz_back.sv
// Back end: output register that hands queued results to the result channel.
module tkz_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  tkz_pkg::result_type head,
   output logic                pop,
   tkz_rsp_if.source           rsp_ch
);
   logic                valid_ff, valid_in;
   tkz_pkg::result_type data_ff;

   assign pop      = head_valid && (!valid_ff || rsp_ch.ready);
   assign valid_in = pop || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop) data_ff <= head;
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.token_kind    = data_ff.kind;
   assign rsp_ch.operator_code = data_ff.opc;
   assign rsp_ch.start_offset  = data_ff.start;
   assign rsp_ch.token_length  = data_ff.len;
   assign rsp_ch.line_number   = data_ff.line;
   assign rsp_ch.decoded_char  = data_ff.chr;
   assign rsp_ch.error_code    = data_ff.err;
   assign rsp_ch.last_of_run   = data_ff.last;

endmodule

FILE: design/script_source_tokenizer_unit.sv
// The first result of an item is registered in the result queue and then in the output register.
// One item per cycle while each item gives at most one result and the result channel is
// ready; results leave at one per cycle while the result channel is ready.
// The four-entry result queue takes an item only when it has room for two results.
// Reset is synchronous: lexer idle at line 1, offsets zero, queue and output empty.
// The keyword buffer is not cleared; only characters of the current identifier are read.
module script_source_tokenizer_unit #(
   parameter int KEYWORD_MAX_LEN = tkz_pkg::KEYWORD_MAX_LEN,
   parameter int POSITION_BITS   = tkz_pkg::POSITION_BITS
) (
   input  logic      clock,
   input  logic      reset,
   tkz_req_if.sink   req_ch,
   tkz_rsp_if.source rsp_ch
);
   tkz_pkg::push_type   push;
   tkz_pkg::result_type head;
   logic                room, head_valid, pop;

   tkz_front #(
      .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock(clock), .reset(reset), .req_ch(req_ch), .room(room), .push(push)
   );

   tkz_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .room(room),
      .head_valid(head_valid), .head(head), .pop(pop)
   );

   tkz_back u_back (
      .clock(clock), .reset(reset), .head_valid(head_valid), .head(head), .pop(pop),
      .rsp_ch(rsp_ch)
   );

endmodule

FILE: design/tkz_checker.sv
// Port-level checks on the tokenizer results, bound to the top level.
module tkz_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  token_kind,
   input logic [3:0]  operator_code,
   input logic [23:0] token_length,
   input logic [1:0]  error_code,
   input logic        last_of_run
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(token_kind) && $stable(token_length))
      else $error("stalled result changed");

   a_eof: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && token_kind == tkz_pkg::KIND_EOF |-> token_length == 24'd0 && last_of_run)
      else $error("eof must be empty and last");

   a_opc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && operator_code != tkz_pkg::OP_NONE |-> token_kind == tkz_pkg::KIND_OP)
      else $error("operator code on a non-operator token");

   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && error_code != tkz_pkg::ERR_NONE |-> token_kind == tkz_pkg::KIND_ERROR)
      else $error("error code on a non-error token");

endmodule

bind script_source_tokenizer_unit tkz_checker u_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .token_kind(rsp_ch.token_kind),
   .operator_code(rsp_ch.operator_code),
   .token_length(rsp_ch.token_length),
   .error_code(rsp_ch.error_code),
   .last_of_run(rsp_ch.last_of_run)
);

FILE: bench/tkz_bench_if.sv
`timescale 1ns / 100ps
// Constants shared by the tokenizer testbench.
package tkz_bench_pkg;
   localparam logic [23:0] POS_TOP = 24'hFFFFFF;
endpackage

FILE: bench/script_source_tokenizer_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the script source tokenizer: directed table, then random text.
module script_source_tokenizer_unit_test;
   import tkz_pkg::*;

   localparam logic [23:0] POS_TOP = tkz_bench_pkg::POS_TOP;

   typedef struct {
      logic [7:0] b;
      logic       fin;
      logic       has_exp;
      logic [5:0] kind0;
      logic [1:0] err0;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #2 clock = ~clock;

   tkz_req_if req_ch ();
   tkz_rsp_if rsp_ch ();

   script_source_tokenizer_unit DUT (.clock(clock), .reset(reset), .req_ch(req_ch),
      .rsp_ch(rsp_ch));

   // Predictor state.
   mode_type    lex_mode;
   logic [7:0]  sym_byte;
   logic [23:0] tok_start, tok_span, src_offset, src_line;
   logic [7:0]  word_buf [7];
   logic [3:0]  word_len;

   result_type  token_queue [$];
   result_type  step_out [$];
   int          mismatch_count = 0;
   int          fail_count = 0;
   int          cycle_count = 0;
   logic        rx_hold = 1'b0;
   logic        no_idle = 1'b0;
   logic [5:0]  directed_kind [$];
   logic [1:0]  directed_err [$];

   function automatic logic [23:0] sat_up(input logic [23:0] v);
      return (v == POS_TOP) ? v : v + 24'd1;
   endfunction

   function automatic void emit(input logic [5:0] kind, input logic [3:0] opc,
                                input logic [23:0] at, input logic [23:0] span,
                                input logic [7:0] chr, input logic [1:0] err);
      result_type r;
      if (step_out.size() >= 2) return;
      r = '{kind: kind, opc: opc, start: at, len: span, line: src_line, chr: chr,
            err: err, last: 1'b0};
      step_out.push_back(r);
   endfunction

   function automatic void emit_tok(input logic [5:0] kind, input logic [3:0] opc);
      emit(kind, opc, tok_start, tok_span, 8'd0, ERR_NONE);
   endfunction

   function automatic void clear_lexer();
      lex_mode = MODE_IDLE;
      sym_byte = 8'd0;
      tok_start = '0;
      tok_span = '0;
      src_offset = '0;
      src_line = 24'd1;
      word_len = '0;
   endfunction

   function automatic logic word_is(input string w);
      if (word_len != w.len()) return 1'b0;
      for (int i = 0; i < w.len(); i++)
         if (word_buf[i] != w[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void close_word(input logic [7:0] follow);
      string kw [21] = '{"func", "let", "if", "else", "for", "while", "end", "return",
         "switch", "case", "default", "try", "catch", "print", "int", "string", "in",
         "use", "as", "True", "False"};
      logic sep;
      sep = follow == " " || follow == 8'h09 || follow == 8'h0A || follow == 8'h0D ||
            follow == 8'h00;
      if (sep && word_is("and")) begin
         emit_tok(KIND_OP, OP_AND);
         return;
      end
      if (sep && word_is("or")) begin
         emit_tok(KIND_OP, OP_OR);
         return;
      end
      for (int k = 0; k < 21; k++)
         if (word_is(kw[k])) begin
            emit_tok(6'(k + 1), OP_NONE);
            return;
         end
      emit_tok(KIND_IDENT, OP_NONE);
   endfunction

   // Returns 1 when the pending mode swallowed the byte.
   function automatic logic finish_pending(input logic [7:0] b);
      logic [7:0] s;
      case (lex_mode)
         MODE_LINECOM: begin
            if (b == 8'h0A) begin
               lex_mode = MODE_IDLE;
               return 1'b0;
            end
            return 1'b1;
         end
         MODE_SLASH: begin
            if (b == "*") begin
               lex_mode = MODE_BLOCK;
               return 1'b1;
            end
            emit_tok(KIND_OP, OP_DIV);
            lex_mode = MODE_IDLE;
            return 1'b0;
         end
         MODE_BLOCK: begin
            if (b == "*") lex_mode = MODE_BLOCKSTAR;
            else if (b == 8'h0A) src_line = sat_up(src_line);
            return 1'b1;
         end
         MODE_BLOCKSTAR: begin
            if (b == "/") lex_mode = MODE_IDLE;
            else if (b != "*") begin
               if (b == 8'h0A) src_line = sat_up(src_line);
               lex_mode = MODE_BLOCK;
            end
            return 1'b1;
         end
         MODE_DOT: begin
            if (b == "/") begin
               tok_span = sat_up(tok_span);
               lex_mode = MODE_PATH;
               return 1'b1;
            end
            if (is_digit(b)) begin
               tok_span = sat_up(tok_span);
               lex_mode = MODE_FRAC;
               return 1'b1;
            end
            if (b == ".") begin
               emit(KIND_ERROR, OP_NONE, tok_start, 24'd1, 8'd0, ERR_UNKNOWN);
               lex_mode = MODE_ERROR;
               return 1'b1;
            end
            emit_tok(KIND_DOT, OP_NONE);
            lex_mode = MODE_IDLE;
            return 1'b0;
         end
         MODE_PATH: begin
            if (is_space(b)) begin
               emit_tok(KIND_PATH, OP_NONE);
               lex_mode = MODE_IDLE;
               return 1'b0;
            end
            tok_span = sat_up(tok_span);
            return 1'b1;
         end
         MODE_IDENT: begin
            if (is_alpha(b) || is_digit(b) || b == "_") begin
               if (word_len < 7) word_buf[word_len] = b;
               if (word_len < 15) word_len++;
               tok_span = sat_up(tok_span);
               return 1'b1;
            end
            close_word(b);
            lex_mode = MODE_IDLE;
            return 1'b0;
         end
         MODE_INT: begin
            if (is_digit(b)) begin
               tok_span = sat_up(tok_span);
               return 1'b1;
            end
            if (b == ".") begin
               tok_span = sat_up(tok_span);
               lex_mode = MODE_FRAC;
               return 1'b1;
            end
            emit_tok(KIND_INT, OP_NONE);
            lex_mode = MODE_IDLE;
            return 1'b0;
         end
         MODE_FRAC: begin
            if (is_digit(b)) begin
               tok_span = sat_up(tok_span);
               return 1'b1;
            end
            emit_tok(KIND_FLOAT, OP_NONE);
            lex_mode = MODE_IDLE;
            return 1'b0;
         end
         MODE_STR: begin
            tok_span = sat_up(tok_span);
            if (b == "\"") begin
               emit_tok(KIND_STRING, OP_NONE);
               lex_mode = MODE_IDLE;
            end else if (b == "\\") lex_mode = MODE_ESC;
            else emit(KIND_STRCHAR, OP_NONE, src_offset, 24'd1, b, ERR_NONE);
            return 1'b1;
         end
         MODE_ESC: begin
            tok_span = sat_up(tok_span);
            emit(KIND_STRCHAR, OP_NONE, (src_offset > 0) ? src_offset - 24'd1 : 24'd0, 24'd2,
                 (b == "n") ? 8'h0A : ((b == "t") ? 8'h09 : b), ERR_NONE);
            lex_mode = MODE_STR;
            return 1'b1;
         end
         MODE_SYM: begin
            s = sym_byte;
            lex_mode = MODE_IDLE;
            if (s == "=") begin
               if (b == "=") begin
                  tok_span = sat_up(tok_span);
                  emit_tok(KIND_OP, OP_EQ);
                  return 1'b1;
               end
               if (b == ">") begin
                  tok_span = sat_up(tok_span);
                  emit_tok(KIND_FATARROW, OP_NONE);
                  return 1'b1;
               end
               emit_tok(KIND_ASSIGN, OP_NONE);
               return 1'b0;
            end
            if (s == "<" || s == ">") begin
               if (b == "=") begin
                  tok_span = sat_up(tok_span);
                  emit_tok(KIND_OP, (s == "<") ? OP_LE : OP_GE);
                  return 1'b1;
               end
               emit_tok(KIND_OP, (s == "<") ? OP_LT : OP_GT);
               return 1'b0;
            end
            if (s == "!") begin
               if (b == "=") begin
                  tok_span = sat_up(tok_span);
                  emit_tok(KIND_OP, OP_NE);
                  return 1'b1;
               end
               emit(KIND_ERROR, OP_NONE, tok_start, 24'd1, 8'd0, ERR_UNKNOWN);
               lex_mode = MODE_ERROR;
               return 1'b1;
            end
            if (s == "-") begin
               if (b == ">") begin
                  tok_span = sat_up(tok_span);
                  emit_tok(KIND_ARROW, OP_NONE);
                  return 1'b1;
               end
               emit_tok(KIND_OP, OP_SUB);
               return 1'b0;
            end
            return 1'b0;
         end
         MODE_ERROR: return 1'b1;
         default: begin
            lex_mode = MODE_IDLE;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic void start_token(input logic [7:0] b);
      sym_type s;
      if (is_space(b)) begin
         if (b == 8'h0A) src_line = sat_up(src_line);
         return;
      end
      tok_start = src_offset;
      tok_span = 24'd1;
      s = single_sym(b);
      if (b == "#") lex_mode = MODE_LINECOM;
      else if (b == "/") lex_mode = MODE_SLASH;
      else if (b == ".") lex_mode = MODE_DOT;
      else if (b == "\"") lex_mode = MODE_STR;
      else if (s.hit) emit_tok(s.kind, s.opc);
      else if (b == "<" || b == ">" || b == "!" || b == "=" || b == "-") begin
         sym_byte = b;
         lex_mode = MODE_SYM;
      end else if (is_alpha(b) || b == "_") begin
         word_buf[0] = b;
         word_len = 4'd1;
         lex_mode = MODE_IDENT;
      end else if (is_digit(b)) lex_mode = MODE_INT;
      else begin
         emit(KIND_ERROR, OP_NONE, tok_start, 24'd1, 8'd0, ERR_UNKNOWN);
         lex_mode = MODE_ERROR;
      end
   endfunction

   function automatic void predict_tokens(input logic [7:0] b, input logic fin_in);
      step_out.delete();
      if (fin_in || b == 8'd0) begin
         if (lex_mode == MODE_PATH) emit_tok(KIND_PATH, OP_NONE);
         else if (lex_mode == MODE_STR || lex_mode == MODE_ESC)
            emit(KIND_ERROR, OP_NONE, tok_start, tok_span, 8'd0, ERR_UNTERM);
         else if (lex_mode != MODE_LINECOM && lex_mode != MODE_BLOCK &&
                  lex_mode != MODE_BLOCKSTAR && lex_mode != MODE_ERROR)
            void'(finish_pending(8'd0));
         emit(KIND_EOF, OP_NONE, src_offset, 24'd0, 8'd0, ERR_NONE);
         clear_lexer();
      end else begin
         if (!finish_pending(b)) start_token(b);
         src_offset = sat_up(src_offset);
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) token_queue.push_back(step_out[i]);
   endfunction

   // Sender.
   task automatic send_byte(input logic [7:0] b, input logic fin_in);
      while (!no_idle && $urandom_range(99) < 29) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.source_byte <= b;
      req_ch.end_of_source <= fin_in;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_tokens(b, fin_in);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (token_queue.size() > 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_printable();
      string p = "abcdefnortuwsxyzTF_09+-*/%<>=!?:;()[]{},.#\"\\ \n\t";
      if ($urandom_range(9) == 0) return 8'($urandom_range(255));
      return p[$urandom_range(p.len() - 1)];
   endfunction

   function automatic string random_phrase();
      string w [] = '{"func ", "let ", "if ", "else ", "for ", "while ", "end ", "return ",
         "switch ", "case ", "default ", "try ", "catch ", "print ", "int ", "string ",
         "in ", "use ", "as ", "True ", "False ", "and ", "or ", "and(", "orx ", "x1_y ",
         "12 ", "3.14 ", ".5 ", "./a/b ", "\"hi\\n\\tq\\\"\" ", "== ", "<= ", ">= ", "!= ",
         "=> ", "-> ", "= ", "< ", "> ", "- ", "/ ", "# note\n", "/* a\n**/ ", ".x ",
         "\n", "(a,b)[c]{d};?:", "\r\n", "7. ", "keywordsverylong "};
      return w[$urandom_range(w.size() - 1)];
   endfunction

   // Receiver and checker.
   always @(posedge clock) begin
      result_type got, want;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{kind: rsp_ch.token_kind, opc: rsp_ch.operator_code,
                    start: rsp_ch.start_offset, len: rsp_ch.token_length,
                    line: rsp_ch.line_number, chr: rsp_ch.decoded_char,
                    err: rsp_ch.error_code, last: rsp_ch.last_of_run};
            if (token_queue.size() == 0) begin
               fail_count++;
               if (mismatch_count < 10)
                  $display("Unexpected result item: %p", got);
               mismatch_count++;
            end else begin
               want = token_queue.pop_front();
               if (directed_kind.size() > 0 && directed_kind[0] != 6'h3F) begin
                  if (got.kind != directed_kind[0] || got.err != directed_err[0]) begin
                     fail_count++;
                     if (mismatch_count < 10)
                        $display("Mismatch: expected kind %0d err %0d, actual kind %0d err %0d",
                                 directed_kind[0], directed_err[0], got.kind, got.err);
                     mismatch_count++;
                  end
               end
               if (directed_kind.size() > 0) begin
                  void'(directed_kind.pop_front());
                  void'(directed_err.pop_front());
               end
               if (got !== want) begin
                  fail_count++;
                  if (mismatch_count < 10)
                     $display("Mismatch: expected %p, actual %p", want, got);
                  mismatch_count++;
               end
            end
         end
         rsp_ch.ready <= !rx_hold && (no_idle || $urandom_range(99) >= 29);
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.source_byte = 8'd0;
      req_ch.end_of_source = 1'b0;
      clear_lexer();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
   end

   // Long receiver hold-off, counted in its own process.
   initial begin
      wait (cycle_count == 1000);
      rx_hold = 1'b1;
      repeat (300) @(posedge clock);
      rx_hold = 1'b0;
   end

   initial begin
      stim_row_type rows [$];
      string phrase;
      int sent;
      @(negedge reset);
      @(posedge clock);
      // Directed table: expected kind typed in where obvious (0x3F means predictor only).
      rows = '{
         '{8'd0, 1'b0, 1'b1, KIND_EOF, ERR_NONE},
         '{8'hFF, 1'b0, 1'b1, KIND_ERROR, ERR_UNKNOWN},
         '{8'h41, 1'b1, 1'b1, KIND_EOF, ERR_NONE},
         '{"!", 1'b0, 1'b0, 6'h3F, ERR_NONE},
         '{"x", 1'b0, 1'b1, KIND_ERROR, ERR_UNKNOWN},
         '{8'd0, 1'b0, 1'b1, KIND_EOF, ERR_NONE},
         '{".", 1'b0, 1'b0, 6'h3F, ERR_NONE},
         '{".", 1'b0, 1'b1, KIND_ERROR, ERR_UNKNOWN},
         '{8'h00, 1'b1, 1'b1, KIND_EOF, ERR_NONE},
         '{"\"", 1'b0, 1'b0, 6'h3F, ERR_NONE},
         '{"\\", 1'b0, 1'b0, 6'h3F, ERR_NONE},
         '{"n", 1'b0, 1'b1, KIND_STRCHAR, ERR_NONE},
         '{8'h80, 1'b0, 1'b1, KIND_STRCHAR, ERR_NONE},
         '{8'h00, 1'b1, 1'b1, KIND_ERROR, ERR_UNTERM},
         '{"/", 1'b0, 1'b0, 6'h3F, ERR_NONE},
         '{"*", 1'b0, 1'b0, 6'h3F, ERR_NONE},
         '{8'h0A, 1'b0, 1'b0, 6'h3F, ERR_NONE},
         '{8'h00, 1'b1, 1'b1, KIND_EOF, ERR_NONE}};
      foreach (rows[i]) begin
         send_byte(rows[i].b, rows[i].fin);
         // Only the first result of a row is typed in; others go to the predictor alone.
         for (int k = 0; k < step_out.size(); k++) begin
            directed_kind.push_back((k == 0 && rows[i].has_exp) ? rows[i].kind0 : 6'h3F);
            directed_err.push_back(rows[i].err0);
         end
      end
      send_text("and or andy < > = - ");
      send_byte(8'd0, 1'b1);
      wait_drained();

      // Random part: mostly well-formed phrases, some noise and ends.
      sent = 0;
      while (sent < 1700) begin
         if (sent > 600 && sent < 900) no_idle = 1'b1;
         else no_idle = 1'b0;
         if ($urandom_range(9) < 7) begin
            phrase = random_phrase();
            send_text(phrase);
            sent += phrase.len();
         end else begin
            send_byte(random_printable(), 1'b0);
            sent++;
         end
         if ($urandom_range(39) == 0) begin
            send_byte(8'($urandom_range(1)) * 8'h5A, 1'b1);
            sent++;
         end
      end
      send_byte(8'd0, 1'b1);
      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      wait (cycle_count == 200000);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
